@@ sv/mgo_pkg.sv @@
// shared types and constants for the glyph outline overlay
`timescale 1ns / 1ps

package mgo_pkg;

    localparam int DIM_W    = 13;
    localparam int ADDR_W   = 24;
    localparam int COLOUR_W = 24;

    // bit positions in the per-pixel write mask, in emission order
    localparam int WR_LEFT   = 0;
    localparam int WR_TOP    = 1;
    localparam int WR_BOTTOM = 2;
    localparam int WR_SELF   = 3;
    localparam int WR_KINDS  = 4;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH    = 3'd0,
        REG_FRAME_HEIGHT   = 3'd1,
        REG_CHROMA_WIDTH   = 3'd2,
        REG_CHROMA_SHIFT_H = 3'd3,
        REG_CHROMA_SHIFT_V = 3'd4,
        REG_FORE_COLOUR    = 3'd5,
        REG_BACK_COLOUR    = 3'd6,
        REG_OUTLINE_ENABLE = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [DIM_W-1:0]    frame_width;
        logic [DIM_W-1:0]    frame_height;
        logic [DIM_W-1:0]    chroma_width;
        logic                chroma_shift_h;
        logic                chroma_shift_v;
        logic [COLOUR_W-1:0] fore_colour;
        logic [COLOUR_W-1:0] back_colour;
        logic                outline_enable;
    } t_cfg;

    // one frame-buffer write before address arithmetic
    typedef struct packed {
        logic                valid;
        logic [DIM_W-1:0]    col;
        logic [DIM_W-1:0]    line;
        logic [COLOUR_W-1:0] colour;
        logic                last;
    } t_wr_req;

endpackage

@@ sv/mgo_regs.sv @@
// configuration register bank behind the apb port
`timescale 1ns / 1ps

module mgo_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output mgo_pkg::t_cfg     o_cfg
);

    mgo_pkg::t_cfg    r_cfg;
    mgo_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx  = mgo_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width    <= 13'd720;
            r_cfg.frame_height   <= 13'd576;
            r_cfg.chroma_width   <= 13'd360;
            r_cfg.chroma_shift_h <= 1'b1;
            r_cfg.chroma_shift_v <= 1'b0;
            r_cfg.fore_colour    <= 24'hFF8080;
            r_cfg.back_colour    <= 24'h108080;
            r_cfg.outline_enable <= 1'b0;
        end else if (w_wr) begin
            case (w_idx)
                mgo_pkg::REG_FRAME_WIDTH:    r_cfg.frame_width    <= pwdata[12:0];
                mgo_pkg::REG_FRAME_HEIGHT:   r_cfg.frame_height   <= pwdata[12:0];
                mgo_pkg::REG_CHROMA_WIDTH:   r_cfg.chroma_width   <= pwdata[12:0];
                mgo_pkg::REG_CHROMA_SHIFT_H: r_cfg.chroma_shift_h <= pwdata[0];
                mgo_pkg::REG_CHROMA_SHIFT_V: r_cfg.chroma_shift_v <= pwdata[0];
                mgo_pkg::REG_FORE_COLOUR:    r_cfg.fore_colour    <= pwdata[23:0];
                mgo_pkg::REG_BACK_COLOUR:    r_cfg.back_colour    <= pwdata[23:0];
                mgo_pkg::REG_OUTLINE_ENABLE: r_cfg.outline_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            mgo_pkg::REG_FRAME_WIDTH:    prdata = {19'd0, r_cfg.frame_width};
            mgo_pkg::REG_FRAME_HEIGHT:   prdata = {19'd0, r_cfg.frame_height};
            mgo_pkg::REG_CHROMA_WIDTH:   prdata = {19'd0, r_cfg.chroma_width};
            mgo_pkg::REG_CHROMA_SHIFT_H: prdata = {31'd0, r_cfg.chroma_shift_h};
            mgo_pkg::REG_CHROMA_SHIFT_V: prdata = {31'd0, r_cfg.chroma_shift_v};
            mgo_pkg::REG_FORE_COLOUR:    prdata = {8'd0, r_cfg.fore_colour};
            mgo_pkg::REG_BACK_COLOUR:    prdata = {8'd0, r_cfg.back_colour};
            mgo_pkg::REG_OUTLINE_ENABLE: prdata = {31'd0, r_cfg.outline_enable};
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

@@ sv/mgo_decode.sv @@
// pixel decode, run tracker and per-pixel write list
`timescale 1ns / 1ps

module mgo_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mgo_pkg::t_cfg       i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [11:0]         i_origin_x,
    input  logic [11:0]         i_origin_y,
    input  logic [7:0]          i_glyph_row,
    input  logic [7:0]          i_glyph_col,
    input  logic                i_pixel_on,
    input  logic                i_above_on,
    input  logic                i_below_on,
    input  logic                i_has_below,
    input  logic                i_row_begin,
    input  logic                i_wr_ready,
    output mgo_pkg::t_wr_req    o_wr
);

    localparam int KW = mgo_pkg::WR_KINDS;
    localparam int DW = mgo_pkg::DIM_W;

    logic          r_inside_run;
    logic          n_inside_run;
    logic [KW-1:0] r_mask;
    logic [KW-1:0] n_mask;
    logic [DW-1:0] r_col;
    logic [DW-1:0] r_line;
    logic          r_self_back;

    logic          w_accept;
    logic [DW-1:0] w_col;
    logic [DW-1:0] w_line;
    logic          w_clipped;
    logic          w_run;
    logic          w_start;
    logic          w_stop;
    logic          w_run_after;
    logic          w_below_in;
    logic [KW-1:0] w_dec_mask;
    logic [KW-1:0] w_rest;
    logic          w_done;

    assign w_col  = DW'({1'b0, i_origin_x}) + DW'({5'd0, i_glyph_col});
    assign w_line = DW'({1'b0, i_origin_y}) + DW'({5'd0, i_glyph_row});
    assign w_clipped = (w_col >= i_cfg.frame_width) || (w_line >= i_cfg.frame_height);
    // row start clears the tracker even for clipped pixels
    assign w_run   = i_row_begin ? 1'b0 : r_inside_run;
    assign w_start = i_cfg.outline_enable && !w_run && i_pixel_on;
    assign w_stop  = i_cfg.outline_enable && w_run && !i_pixel_on;
    assign w_run_after = w_start ? 1'b1 : (w_stop ? 1'b0 : w_run);
    assign w_below_in  = ({1'b0, w_line} + 14'd1) < {1'b0, i_cfg.frame_height};

    always_comb begin
        w_dec_mask = '0;
        if (!w_clipped) begin
            w_dec_mask[mgo_pkg::WR_LEFT]   = w_start && (i_glyph_col != 8'd0);
            w_dec_mask[mgo_pkg::WR_TOP]    = i_cfg.outline_enable && w_run_after &&
                                             (i_glyph_row != 8'd0) && !i_above_on;
            w_dec_mask[mgo_pkg::WR_BOTTOM] = i_cfg.outline_enable && w_run_after &&
                                             i_has_below && !i_below_on && w_below_in;
            w_dec_mask[mgo_pkg::WR_SELF]   = i_pixel_on || w_stop;
        end
    end

    assign w_accept     = i_valid && o_ready;
    assign n_inside_run = w_clipped ? w_run : w_run_after;

    // clear lowest pending write
    assign w_rest  = r_mask & (r_mask - KW'(1));
    assign w_done  = (r_mask != '0) && i_wr_ready;
    assign o_ready = (r_mask == '0) || (w_done && (w_rest == '0));

    always_comb begin
        if (w_accept) begin
            n_mask = w_dec_mask;
        end else if (w_done) begin
            n_mask = w_rest;
        end else begin
            n_mask = r_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside_run <= 1'b0;
            r_mask       <= '0;
        end else begin
            r_mask <= n_mask;
            if (w_accept) begin
                r_inside_run <= n_inside_run;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_col       <= w_col;
            r_line      <= w_line;
            r_self_back <= w_stop;
        end
    end

    always_comb begin
        o_wr.valid  = (r_mask != '0);
        o_wr.last   = (w_rest == '0);
        o_wr.col    = r_col;
        o_wr.line   = r_line;
        o_wr.colour = i_cfg.back_colour;
        if (r_mask[mgo_pkg::WR_LEFT]) begin
            o_wr.col = r_col - DW'(1);
        end else if (r_mask[mgo_pkg::WR_TOP]) begin
            o_wr.line = r_line - DW'(1);
        end else if (r_mask[mgo_pkg::WR_BOTTOM]) begin
            o_wr.line = r_line + DW'(1);
        end else if (!r_self_back) begin
            o_wr.colour = i_cfg.fore_colour;
        end
    end

endmodule

@@ sv/mgo_emit.sv @@
// address arithmetic and output register of the write stream
`timescale 1ns / 1ps

module mgo_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mgo_pkg::t_cfg       i_cfg,
    input  mgo_pkg::t_wr_req    i_wr,
    output logic                o_wr_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [71:0]         o_data,
    output logic                o_last
);

    localparam int DW = mgo_pkg::DIM_W;
    localparam int AW = mgo_pkg::ADDR_W;

    logic              r_valid;
    logic [AW-1:0]     r_luma;
    logic [AW-1:0]     r_chroma;
    logic [23:0]       r_colour;
    logic              r_last;

    logic [2*DW-1:0]   w_luma_prod;
    logic [2*DW-1:0]   w_chroma_prod;
    logic [DW-1:0]     w_ccol;
    logic [DW-1:0]     w_cline;
    logic [AW-1:0]     w_luma;
    logic [AW-1:0]     w_chroma;

    assign w_ccol        = i_wr.col >> i_cfg.chroma_shift_h;
    assign w_cline       = i_wr.line >> i_cfg.chroma_shift_v;
    assign w_luma_prod   = {{DW{1'b0}}, i_wr.line} * {{DW{1'b0}}, i_cfg.frame_width};
    assign w_chroma_prod = {{DW{1'b0}}, w_cline} * {{DW{1'b0}}, i_cfg.chroma_width};
    assign w_luma   = w_luma_prod[AW-1:0] + AW'(i_wr.col);
    assign w_chroma = w_chroma_prod[AW-1:0] + AW'(w_ccol);

    assign o_wr_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_wr_ready) begin
            r_valid <= i_wr.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_wr_ready && i_wr.valid) begin
            r_luma   <= w_luma;
            r_chroma <= w_chroma;
            r_colour <= i_wr.colour;
            r_last   <= i_wr.last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {r_colour[7:0], r_colour[15:8], r_colour[23:16], r_chroma, r_luma};
    assign o_last  = r_last;

endmodule

@@ sv/mono_glyph_outline_overlay.sv @@
// top level of the monochrome glyph overlay with outline
`timescale 1ns / 1ps

// channel        dir  handshake                 payload
// s_axis pixels  in   tvalid / tready           tdata (48 bits)
// m_axis writes  out  tvalid / tready           tdata (72 bits), tlast
// apb config     in   psel, penable, pready     paddr, pwdata, prdata
//
// frame-buffer writes go out one per cycle while the output does not stall, one to four per pixel;
// a pixel that causes none does not hold the input; the single output write port sets this.
// the next pixel is taken in the cycle its predecessor's last write leaves.
// synchronous active-low reset clears the run flag and both valid paths.
// output stalls hold the write register and then the pixel register.

module mono_glyph_outline_overlay (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // origin_x, origin_y, glyph_row, glyph_col, pixel_on, above_on,
    // below_on, has_below, row_begin, zero pad
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // luma_addr, chroma_addr, y_value, u_value, v_value
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    mgo_pkg::t_cfg    w_cfg;
    mgo_pkg::t_wr_req w_wr;
    logic             w_wr_ready;

    mgo_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    mgo_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_origin_x  (s_axis_tdata[11:0]),
        .i_origin_y  (s_axis_tdata[23:12]),
        .i_glyph_row (s_axis_tdata[31:24]),
        .i_glyph_col (s_axis_tdata[39:32]),
        .i_pixel_on  (s_axis_tdata[40]),
        .i_above_on  (s_axis_tdata[41]),
        .i_below_on  (s_axis_tdata[42]),
        .i_has_below (s_axis_tdata[43]),
        .i_row_begin (s_axis_tdata[44]),
        .i_wr_ready  (w_wr_ready),
        .o_wr        (w_wr)
    );

    mgo_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_wr       (w_wr),
        .o_wr_ready (w_wr_ready),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata),
        .o_last     (m_axis_tlast)
    );

endmodule

@@ verif/tb_mono_glyph_outline_overlay.sv @@
// self-checking testbench for the glyph outline overlay: directed and random pixels
`timescale 1ns / 1ps

module tb_mono_glyph_outline_overlay;

    localparam int QUIET_LIMIT  = 1000;
    localparam int SETTLE_TICKS = 16;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_PIXELS  = 45;

    // lowest bit first: origin_x, origin_y, glyph_row, glyph_col, pixel_on,
    // above_on, below_on, has_below, row_begin, pad
    typedef struct packed {
        logic [2:0]  pad;
        logic        row_begin;
        logic        has_below;
        logic        below_on;
        logic        above_on;
        logic        pixel_on;
        logic [7:0]  glyph_col;
        logic [7:0]  glyph_row;
        logic [11:0] origin_y;
        logic [11:0] origin_x;
    } t_glyph_pixel;

    // lowest bit first: luma_addr, chroma_addr, y, u, v, then tlast on top
    typedef struct packed {
        logic        last;
        logic [7:0]  v_value;
        logic [7:0]  u_value;
        logic [7:0]  y_value;
        logic [23:0] chroma_addr;
        logic [23:0] luma_addr;
    } t_fb_write;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_SLOW
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    mono_glyph_outline_overlay i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    t_glyph_pixel  pending_pixels[$];
    t_fb_write     expected_writes[$];
    t_glyph_pixel  pixel_on_bus;
    mgo_pkg::t_cfg cfg;
    logic          run_active;

    int pixels_sent     = 0;
    int writes_checked  = 0;
    int mismatch_count  = 0;
    int reg_writes      = 0;
    int burst_left      = 0;
    int gap_left        = 0;
    int quiet_cycles    = 0;
    int mode_left       = 0;
    int slow_tick       = 0;
    t_rx_mode  rx_mode  = RX_OPEN;
    t_fb_write got_write;
    t_fb_write want_write;

    function automatic t_fb_write fb_write(input int unsigned col, input int unsigned line,
                                           input logic [23:0] colour);
        t_fb_write w;
        w.luma_addr   = 24'(col + line * cfg.frame_width);
        w.chroma_addr = 24'((col >> cfg.chroma_shift_h) +
                            (line >> cfg.chroma_shift_v) * cfg.chroma_width);
        w.y_value     = colour[23:16];
        w.u_value     = colour[15:8];
        w.v_value     = colour[7:0];
        w.last        = 1'b0;
        return w;
    endfunction

    // writes for one pixel in order: left edge, top, bottom, the pixel itself
    function automatic void predict_overlay_writes(input t_glyph_pixel p);
        int unsigned col;
        int unsigned line;
        logic        paint_self;
        logic [23:0] self_colour;
        t_fb_write   found[$];
        t_fb_write   w;
        col         = p.origin_x + p.glyph_col;
        line        = p.origin_y + p.glyph_row;
        paint_self  = p.pixel_on;
        self_colour = cfg.fore_colour;
        if (p.row_begin)
            run_active = 1'b0;
        if (col >= cfg.frame_width || line >= cfg.frame_height)
            return;
        if (cfg.outline_enable) begin
            if (!run_active && p.pixel_on) begin
                run_active = 1'b1;
                if (p.glyph_col != 0)
                    found.push_back(fb_write(col - 1, line, cfg.back_colour));
            end else if (run_active && !p.pixel_on) begin
                // first clear pixel after a run closes it in the outline colour
                run_active  = 1'b0;
                paint_self  = 1'b1;
                self_colour = cfg.back_colour;
            end
            if (run_active) begin
                if (p.glyph_row != 0 && !p.above_on)
                    found.push_back(fb_write(col, line - 1, cfg.back_colour));
                if (p.has_below && !p.below_on && line + 1 < cfg.frame_height)
                    found.push_back(fb_write(col, line + 1, cfg.back_colour));
            end
        end
        if (paint_self)
            found.push_back(fb_write(col, line, self_colour));
        foreach (found[i]) begin
            w      = found[i];
            w.last = (i == found.size() - 1);
            expected_writes.push_back(w);
        end
    endfunction

    // pixel driver: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_overlay_writes(pixel_on_bus);
                pixels_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0 || pending_pixels.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    pixel_on_bus = pending_pixels.pop_front();
                    s_axis_tdata  <= pixel_on_bus;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // write monitor and receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
                got_write = {m_axis_tlast, m_axis_tdata};
                writes_checked++;
                if (expected_writes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: write with none expected: luma %h chroma %h yuv %h %h %h",
                                 $realtime, got_write.luma_addr, got_write.chroma_addr,
                                 got_write.y_value, got_write.u_value, got_write.v_value);
                end else begin
                    want_write = expected_writes.pop_front();
                    if (got_write.luma_addr !== want_write.luma_addr ||
                        got_write.chroma_addr !== want_write.chroma_addr ||
                        got_write.y_value !== want_write.y_value ||
                        got_write.u_value !== want_write.u_value ||
                        got_write.v_value !== want_write.v_value ||
                        got_write.last !== want_write.last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: write mismatch", $realtime);
                            $display("  expected luma %h chroma %h yuv %h %h %h last %b",
                                     want_write.luma_addr, want_write.chroma_addr,
                                     want_write.y_value, want_write.u_value,
                                     want_write.v_value, want_write.last);
                            $display("  actual   luma %h chroma %h yuv %h %h %h last %b",
                                     got_write.luma_addr, got_write.chroma_addr,
                                     got_write.y_value, got_write.u_value,
                                     got_write.v_value, got_write.last);
                        end
                    end
                end
            end
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(16, 64);
            end else begin
                mode_left--;
            end
            slow_tick++;
            case (rx_mode)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
                default:   m_axis_tready <= (slow_tick % 4 == 0);
            endcase
        end
    end

    // watchdog on cycles with no transaction on any port
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d writes outstanding",
                     QUIET_LIMIT, expected_writes.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic apb_write_reg(input mgo_pkg::t_reg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            mgo_pkg::REG_FRAME_WIDTH:    cfg.frame_width    = value[12:0];
            mgo_pkg::REG_FRAME_HEIGHT:   cfg.frame_height   = value[12:0];
            mgo_pkg::REG_CHROMA_WIDTH:   cfg.chroma_width   = value[12:0];
            mgo_pkg::REG_CHROMA_SHIFT_H: cfg.chroma_shift_h = value[0];
            mgo_pkg::REG_CHROMA_SHIFT_V: cfg.chroma_shift_v = value[0];
            mgo_pkg::REG_FORE_COLOUR:    cfg.fore_colour    = value[23:0];
            mgo_pkg::REG_BACK_COLOUR:    cfg.back_colour    = value[23:0];
            mgo_pkg::REG_OUTLINE_ENABLE: cfg.outline_enable = value[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic add_pixel(input int ox, input int oy, input int row, input int col,
                             input bit on, input bit above, input bit below,
                             input bit has_below, input bit row_begin);
        t_glyph_pixel p;
        p.pad       = '0;
        p.origin_x  = 12'(ox);
        p.origin_y  = 12'(oy);
        p.glyph_row = 8'(row);
        p.glyph_col = 8'(col);
        p.pixel_on  = on;
        p.above_on  = above;
        p.below_on  = below;
        p.has_below = has_below;
        p.row_begin = row_begin;
        pending_pixels.push_back(p);
    endtask

    // all pixels accepted, every expected write seen, then a little slack
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_pixels.size() != 0 || s_axis_tvalid || expected_writes.size() != 0);
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    function automatic int unsigned pick_dimension();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(1, 16);
            1:       return $urandom_range(17, 4096);
            2:       return 4096;
            default: return 720;
        endcase
    endfunction

    task automatic random_phase(input int budget);
        int unsigned fw;
        int unsigned fh;
        int          queued;
        int          w;
        int          h;
        int          ox;
        int          oy;
        int          density;
        bit          glyph_bits [0:5][0:11];
        fw = pick_dimension();
        fh = pick_dimension();
        apb_write_reg(mgo_pkg::REG_FRAME_WIDTH, fw);
        apb_write_reg(mgo_pkg::REG_FRAME_HEIGHT, fh);
        apb_write_reg(mgo_pkg::REG_CHROMA_WIDTH, $urandom_range(0, 4096));
        apb_write_reg(mgo_pkg::REG_CHROMA_SHIFT_H, $urandom_range(0, 1));
        apb_write_reg(mgo_pkg::REG_CHROMA_SHIFT_V, $urandom_range(0, 1));
        apb_write_reg(mgo_pkg::REG_FORE_COLOUR, $urandom_range(0, 24'hFFFFFF));
        apb_write_reg(mgo_pkg::REG_BACK_COLOUR, $urandom_range(0, 24'hFFFFFF));
        apb_write_reg(mgo_pkg::REG_OUTLINE_ENABLE, ($urandom_range(0, 3) != 0));
        queued = 0;
        while (queued < budget) begin
            if ($urandom_range(0, 5) == 0) begin
                // stray pixel with every field random
                add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                          $urandom_range(0, 1), $urandom_range(0, 1));
                queued++;
            end else begin
                // whole glyph, raster order, mostly placed inside the frame
                w       = $urandom_range(1, 12);
                h       = $urandom_range(1, 6);
                ox      = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                      : $urandom_range(0, fw - 1);
                oy      = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                      : $urandom_range(0, fh - 1);
                density = $urandom_range(25, 75);
                for (int r = 0; r < h; r++)
                    for (int c = 0; c < w; c++)
                        glyph_bits[r][c] = ($urandom_range(0, 99) < density);
                for (int r = 0; r < h; r++)
                    for (int c = 0; c < w; c++)
                        add_pixel(ox, oy, r, c, glyph_bits[r][c],
                                  (r > 0) ? glyph_bits[r-1][c] : $urandom_range(0, 1),
                                  (r < h - 1) ? glyph_bits[r+1][c] : $urandom_range(0, 1),
                                  (r < h - 1), (c == 0));
                queued += w * h;
            end
        end
        wait_idle();
    endtask

    initial begin
        cfg.frame_width    = 720;
        cfg.frame_height   = 576;
        cfg.chroma_width   = 360;
        cfg.chroma_shift_h = 1'b1;
        cfg.chroma_shift_v = 1'b0;
        cfg.fore_colour    = 24'hFF8080;
        cfg.back_colour    = 24'h108080;
        cfg.outline_enable = 1'b0;
        run_active         = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, outline off: plain set pixels and right-hand clipping
        add_pixel(0, 0, 0, 0, 1, 0, 0, 0, 1);
        add_pixel(700, 100, 255, 19, 1, 0, 0, 1, 0);
        add_pixel(700, 100, 255, 20, 1, 0, 0, 1, 0);
        add_pixel(10, 10, 1, 1, 0, 0, 0, 1, 0);
        wait_idle();

        // outline on: run edges, neighbours, row start and clipping inside a run
        apb_write_reg(mgo_pkg::REG_OUTLINE_ENABLE, 1);
        add_pixel(100, 50, 2, 0, 1, 0, 0, 1, 1);
        add_pixel(100, 50, 2, 1, 1, 1, 1, 1, 0);
        add_pixel(100, 50, 2, 2, 0, 0, 0, 1, 0);
        add_pixel(100, 50, 2, 3, 1, 0, 0, 1, 0);
        add_pixel(100, 50, 3, 0, 0, 0, 0, 1, 1);
        add_pixel(200, 60, 0, 1, 1, 0, 1, 0, 0);
        add_pixel(4095, 60, 0, 2, 1, 0, 0, 0, 0);
        add_pixel(200, 60, 0, 3, 0, 0, 0, 0, 0);
        add_pixel(200, 60, 0, 4, 1, 0, 0, 0, 0);
        add_pixel(4095, 60, 1, 0, 1, 0, 0, 0, 1);
        add_pixel(200, 60, 1, 1, 0, 0, 0, 0, 0);
        add_pixel(300, 570, 5, 0, 1, 1, 0, 1, 1);
        wait_idle();

        // widest legal frame, bottom-right corner, extreme colours
        apb_write_reg(mgo_pkg::REG_FRAME_WIDTH, 4096);
        apb_write_reg(mgo_pkg::REG_FRAME_HEIGHT, 4096);
        apb_write_reg(mgo_pkg::REG_CHROMA_WIDTH, 4096);
        apb_write_reg(mgo_pkg::REG_CHROMA_SHIFT_H, 0);
        apb_write_reg(mgo_pkg::REG_CHROMA_SHIFT_V, 1);
        apb_write_reg(mgo_pkg::REG_FORE_COLOUR, 32'h00FF_FFFF);
        apb_write_reg(mgo_pkg::REG_BACK_COLOUR, 32'h0000_0000);
        add_pixel(4000, 4000, 95, 95, 1, 0, 0, 1, 1);
        wait_idle();

        // full 13-bit sizes so both addresses wrap
        apb_write_reg(mgo_pkg::REG_FRAME_WIDTH, 8191);
        apb_write_reg(mgo_pkg::REG_FRAME_HEIGHT, 8191);
        apb_write_reg(mgo_pkg::REG_CHROMA_WIDTH, 8191);
        add_pixel(4095, 4095, 255, 255, 1, 0, 0, 1, 1);
        wait_idle();

        // one-pixel frame with no chroma stride
        apb_write_reg(mgo_pkg::REG_FRAME_WIDTH, 1);
        apb_write_reg(mgo_pkg::REG_FRAME_HEIGHT, 1);
        apb_write_reg(mgo_pkg::REG_CHROMA_WIDTH, 0);
        apb_write_reg(mgo_pkg::REG_CHROMA_SHIFT_H, 1);
        add_pixel(0, 0, 0, 0, 1, 0, 0, 1, 1);
        add_pixel(0, 0, 0, 1, 1, 0, 0, 1, 0);
        wait_idle();

        // zero width, then zero height: everything clipped
        apb_write_reg(mgo_pkg::REG_FRAME_WIDTH, 0);
        add_pixel(0, 0, 0, 0, 1, 0, 0, 1, 1);
        wait_idle();
        apb_write_reg(mgo_pkg::REG_FRAME_WIDTH, 5);
        apb_write_reg(mgo_pkg::REG_FRAME_HEIGHT, 0);
        add_pixel(0, 0, 0, 0, 1, 0, 0, 1, 1);
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
            random_phase(PHASE_PIXELS);

        $display("run covered %0d glyph pixels and %0d frame-buffer writes",
                 pixels_sent, writes_checked);
        $display("across %0d register writes, outline on and off, clipped and wrapped frames",
                 reg_writes);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d write errors", mismatch_count);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
